// File: rtl/wrle_pkg.sv
// Shared types and constants for the word run-length encoder.
// Used by the front classifier, the command queue, the back expander and the top level.
package wrle_pkg;

   localparam int SCREEN_WORDS = 16000;
   localparam int MAX_REPEAT   = 32767;
   localparam int QUEUE_DEPTH  = 4;
   localparam int OPS_PER_CMD  = 3;

   localparam int POS_W  = $clog2(SCREEN_WORDS + 1);
   localparam int REP_W  = 15;
   localparam int LIT_W  = POS_W;
   localparam int LEN_W  = (LIT_W > REP_W) ? LIT_W : REP_W;
   localparam int WORD_W = 16;
   localparam int CTRL_TOTAL_W = 16;
   localparam int DATA_TOTAL_W = 14;
   localparam int RSP_DATA_W   = 48;
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int OPIDX_W = $clog2(OPS_PER_CMD);

   localparam logic KIND_CONTROL = 1'b0;
   localparam logic KIND_DATA    = 1'b1;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_REPEAT,
      OP_LITERAL,
      OP_DATA
   } op_code_type;

   typedef struct packed {
      op_code_type         code;
      logic [LEN_W-1:0]    len;
      logic [WORD_W-1:0]   word;
   } op_type;

   typedef struct packed {
      logic                         final_flag;
      op_type [OPS_PER_CMD-1:0]     ops;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

// File: rtl/wrle_front.sv
// Front classifier: tracks held word, run lengths and screen position, and turns
// each accepted word into at most one command of up to three output operations. Uses wrle_pkg.
module wrle_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [15:0]             req_tdata,   // [15:0] screen_word
   input  logic                    req_tlast,   // last_word
   input  logic                    queue_full,
   output logic                    push,
   output wrle_pkg::cmd_type       push_cmd
);
   import wrle_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LITERAL,
      PH_REPEAT
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [WORD_W-1:0]     held_ff, held_in;
   logic [REP_W-1:0]      rep_ff, rep_in;
   logic [LIT_W-1:0]      lit_ff, lit_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [WORD_W-1:0]     x;
   logic                  last;
   logic                  accept;
   logic [OPIDX_W-1:0]    cnt;
   cmd_type               cmd;

   assign x          = req_tdata[WORD_W-1:0];
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && (cmd.ops[0].code != OP_NONE);
   assign push_cmd   = cmd;

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      rep_in   = rep_ff;
      lit_in   = lit_ff;
      pos_in   = pos_ff + 1'b1;
      cmd      = '0;
      cnt      = '0;
      last     = req_tlast || ((pos_ff + 1'b1) >= POS_W'(SCREEN_WORDS));
      unique case (phase_ff)
         PH_IDLE: begin
            held_in  = x;
            rep_in   = '0;
            lit_in   = '0;
            phase_in = PH_LITERAL;
            if (last) begin
               cmd.ops[0] = '{code: OP_DATA, len: '0, word: x};
               cmd.ops[1] = '{code: OP_LITERAL, len: LEN_W'(1), word: '0};
            end
         end
         PH_REPEAT: begin
            if (x == held_ff && rep_ff < REP_W'(MAX_REPEAT)) begin
               rep_in = rep_ff + 1'b1;
               if (last) begin
                  cmd.ops[0] = '{code: OP_REPEAT, len: LEN_W'(rep_in), word: held_ff};
               end
            end else begin
               cmd.ops[0] = '{code: OP_REPEAT, len: LEN_W'(rep_ff), word: held_ff};
               held_in  = x;
               rep_in   = '0;
               lit_in   = '0;
               phase_in = PH_LITERAL;
               if (last) begin
                  cmd.ops[1] = '{code: OP_DATA, len: '0, word: x};
                  cmd.ops[2] = '{code: OP_LITERAL, len: LEN_W'(1), word: '0};
               end
            end
         end
         default: begin
            if (x == held_ff) begin
               if (lit_ff != '0) begin
                  cmd.ops[cnt] = '{code: OP_LITERAL, len: LEN_W'(lit_ff), word: '0};
                  cnt = cnt + 1'b1;
               end
               lit_in   = '0;
               rep_in   = REP_W'(2);
               phase_in = PH_REPEAT;
               if (last) begin
                  cmd.ops[cnt] = '{code: OP_REPEAT, len: LEN_W'(2), word: held_ff};
               end
            end else begin
               cmd.ops[0] = '{code: OP_DATA, len: '0, word: held_ff};
               lit_in  = lit_ff + 1'b1;
               held_in = x;
               if (last) begin
                  cmd.ops[1] = '{code: OP_DATA, len: '0, word: x};
                  cmd.ops[2] = '{code: OP_LITERAL, len: LEN_W'(lit_ff) + LEN_W'(2),
                                 word: '0};
               end
            end
         end
      endcase
      if (last) begin
         cmd.final_flag = 1'b1;
         phase_in = PH_IDLE;
         held_in  = '0;
         rep_in   = '0;
         lit_in   = '0;
         pos_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= '0;
         rep_ff   <= '0;
         lit_ff   <= '0;
         pos_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         rep_ff   <= rep_in;
         lit_ff   <= lit_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

// File: rtl/wrle_queue.sv
// Short command queue between the front classifier and the back expander.
// Register storage, one write and one read at the head per cycle. Uses wrle_pkg.
module wrle_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  wrle_pkg::cmd_type          push_cmd,
   output logic                       full,
   output wrle_pkg::queue_head_type   head,
   input  logic                       pop
);
   import wrle_pkg::*;

   cmd_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ff, wr_in;
   logic [QPTR_W-1:0]    rd_ff, rd_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   logic                 do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = mem_ff[rd_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/wrle_back.sv
// Back expander: walks the operations of the queue head, one result per cycle unless stalled,
// keeps the control and data totals and drives the registered result channel. Uses wrle_pkg.
module wrle_back (
   input  logic                             clock,
   input  logic                             reset,
   input  wrle_pkg::queue_head_type         head,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [wrle_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // [15:0] out_value,
                                                        // [31:16] control_total,
                                                        // [45:32] word_total
   output logic                             rsp_tuser,  // stream_kind
   output logic                             rsp_tlast   // final_result
);
   import wrle_pkg::*;

   logic [OPIDX_W-1:0]       op_idx_ff, op_idx_in;
   logic [1:0]               sub_ff, sub_in;
   logic [CTRL_TOTAL_W-1:0]  ctrl_cnt_ff, ctrl_cnt_in, ctrl_total;
   logic [DATA_TOTAL_W-1:0]  data_cnt_ff, data_cnt_in, data_total;
   logic                     valid_ff;
   logic [WORD_W-1:0]        value_ff;
   logic                     kind_ff, final_ff;
   logic [CTRL_TOTAL_W-1:0]  ctrl_out_ff;
   logic [DATA_TOTAL_W-1:0]  data_out_ff;

   op_type                   op;
   logic [LEN_W-1:0]         hi;
   logic [1:0]               last_sub;
   logic                     kind;
   logic [WORD_W-1:0]        value;
   logic                     load, op_done, next_valid, final_res;
   logic [OPIDX_W-1:0]       next_idx;

   assign op       = head.cmd.ops[op_idx_ff];
   assign hi       = op.len >> 8;
   assign next_idx = op_idx_ff + 1'b1;

   always_comb begin
      kind     = KIND_CONTROL;
      value    = '0;
      last_sub = '0;
      unique case (op.code)
         OP_REPEAT: begin
            if (op.len < LEN_W'(128)) begin
               last_sub = 2'd1;
               if (sub_ff == 2'd0) begin
                  value = {8'd0, op.len[7:0]};
               end else begin
                  kind  = KIND_DATA;
                  value = op.word;
               end
            end else begin
               last_sub = 2'd3;
               case (sub_ff)
                  2'd0:    value = '0;
                  2'd1:    value = {8'd0, hi[7:0]};
                  2'd2:    value = {8'd0, op.len[7:0]};
                  default: begin
                     kind  = KIND_DATA;
                     value = op.word;
                  end
               endcase
            end
         end
         OP_LITERAL: begin
            if (op.len <= LEN_W'(128)) begin
               value = {8'd0, 8'(8'd0 - op.len[7:0])};
            end else begin
               last_sub = 2'd2;
               case (sub_ff)
                  2'd0:    value = 16'd1;
                  2'd1:    value = {8'd0, hi[7:0]};
                  default: value = {8'd0, op.len[7:0]};
               endcase
            end
         end
         OP_DATA: begin
            kind  = KIND_DATA;
            value = op.word;
         end
         default: begin
            value = '0;
         end
      endcase
   end

   always_comb begin
      load       = head.valid && (!valid_ff || rsp_tready);
      op_done    = (sub_ff == last_sub);
      next_valid = (op_idx_ff != OPIDX_W'(OPS_PER_CMD - 1))
                   && (head.cmd.ops[next_idx].code != OP_NONE);
      pop        = load && op_done && !next_valid;
      final_res  = pop && head.cmd.final_flag;
      ctrl_total = ctrl_cnt_ff + ((kind == KIND_CONTROL) ? 1'b1 : 1'b0);
      data_total = data_cnt_ff + ((kind == KIND_DATA) ? 1'b1 : 1'b0);
      ctrl_cnt_in = final_res ? '0 : ctrl_total;
      data_cnt_in = final_res ? '0 : data_total;
      if (!op_done) begin
         op_idx_in = op_idx_ff;
         sub_in    = sub_ff + 1'b1;
      end else if (next_valid) begin
         op_idx_in = next_idx;
         sub_in    = '0;
      end else begin
         op_idx_in = '0;
         sub_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         op_idx_ff   <= '0;
         sub_ff      <= '0;
         ctrl_cnt_ff <= '0;
         data_cnt_ff <= '0;
      end else if (load) begin
         valid_ff    <= 1'b1;
         op_idx_ff   <= op_idx_in;
         sub_ff      <= sub_in;
         ctrl_cnt_ff <= ctrl_cnt_in;
         data_cnt_ff <= data_cnt_in;
      end else if (rsp_tready) begin
         valid_ff    <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff    <= value;
         kind_ff     <= kind;
         final_ff    <= final_res;
         ctrl_out_ff <= ctrl_total;
         data_out_ff <= data_total;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = final_ff;
   assign rsp_tdata  = {2'b00, data_out_ff, ctrl_out_ff, value_ff};

endmodule

// File: rtl/word_run_length_encoder_core.sv
// Word run-length encoder top level: front classifier, command queue, back expander.
// Depends on wrle_pkg, wrle_front, wrle_queue and wrle_back.
//
// Usage:
//   req channel: one 16-bit screen word per request in tdata, tlast on the final
//   word of a screen. A screen also closes on its SCREEN_WORDS-th word.
//   rsp channel: zero or more output items per request; tuser gives the kind (control byte
//   or data word), tdata holds the value and the running control and data totals,
//   tlast marks the last item of the screen, where the totals are final.
//   Throughput: one word per cycle is taken while the command queue has room.
//   The back side emits one item per cycle; a word causes zero to six items, so a
//   burst of items holds the front back once the four-entry queue fills.
//   Path: the first item caused by a word is written into a queue entry and then
//   into the output register before it appears on the rsp channel.
//   Reset: synchronous; clears run state, queue and totals; no items pending.
//   Stall: when rsp_tready is low the output register holds, the back side stops,
//   and the front keeps taking words until the queue is full.
module word_run_length_encoder_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,   // [15:0] screen_word
   input  logic                             req_tlast,   // last_word
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [wrle_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [15:0] out_value,
                                                         // [31:16] control_total,
                                                         // [45:32] word_total
   output logic                             rsp_tuser,   // stream_kind
   output logic                             rsp_tlast    // final_result
);
   import wrle_pkg::*;

   logic             queue_full;
   logic             push;
   cmd_type          push_cmd;
   queue_head_type   head;
   logic             pop;

   wrle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   wrle_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .head     (head),
      .pop      (pop)
   );

   wrle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: bench/word_run_length_encoder_core_tb.sv
// Self-checking bench for word_run_length_encoder_core: drives screen words with random
// idling on both stream sides and checks every output item against a built-in encoder.
// Depends on wrle_pkg and the word_run_length_encoder_core RTL.
module word_run_length_encoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wrle_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int REPEAT_CAP  = (MAX_REPEAT > 32767) ? 32767 : MAX_REPEAT;

   typedef enum logic [1:0] {
      CODE_IDLE,
      CODE_LITERAL,
      CODE_REPEAT
   } code_phase_type;

   typedef struct packed {
      logic                    kind;
      logic [WORD_W-1:0]       value;
      logic                    final_flag;
      logic [CTRL_TOTAL_W-1:0] ctl_total;
      logic [DATA_TOTAL_W-1:0] word_total;
   } enc_item_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   // encoder state as predicted
   logic [WORD_W-1:0]       held_word  = '0;
   logic                    held_valid = 1'b0;
   logic [REP_W-1:0]        run_len    = '0;
   logic [LIT_W-1:0]        lit_len    = '0;
   code_phase_type          coding     = CODE_IDLE;
   logic [CTRL_TOTAL_W-1:0] ctl_count  = '0;
   logic [DATA_TOTAL_W-1:0] data_count = '0;
   int                      word_pos   = 0;

   enc_item_type expected_q[$];

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int stall_cycles  = 0;
   int err_count     = 0;
   int words_in      = 0;
   int screens_out   = 0;
   int ctl_seen      = 0;
   int data_seen     = 0;

   word_run_length_encoder_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   function automatic void push_item(input logic kind, input logic [15:0] value);
      enc_item_type item;
      if (kind == KIND_CONTROL) begin
         ctl_count++;
         item.value = {8'h00, value[7:0]};
      end else begin
         data_count++;
         item.value = value;
      end
      item.kind       = kind;
      item.final_flag = 1'b0;
      item.ctl_total  = ctl_count;
      item.word_total = data_count;
      expected_q.push_back(item);
   endfunction

   function automatic void close_repeat();
      int n;
      n = run_len;
      if (n < 128) begin
         push_item(KIND_CONTROL, 16'(n));
      end else begin
         push_item(KIND_CONTROL, 16'h0000);
         push_item(KIND_CONTROL, 16'(n >> 8));
         push_item(KIND_CONTROL, 16'(n));
      end
      push_item(KIND_DATA, held_word);
   endfunction

   function automatic void close_literal();
      int n;
      n = lit_len;
      if (n == 0) return;
      if (n <= 128) begin
         push_item(KIND_CONTROL, 16'(256 - n));
      end else begin
         push_item(KIND_CONTROL, 16'h0001);
         push_item(KIND_CONTROL, 16'(n >> 8));
         push_item(KIND_CONTROL, 16'(n));
      end
      lit_len = '0;
   endfunction

   function automatic void encode_word(input logic [15:0] w, input logic last);
      logic fin;
      fin = last;
      word_pos++;
      if (word_pos >= SCREEN_WORDS) fin = 1'b1;

      if (!held_valid || coding == CODE_IDLE) begin
         held_word  = w;
         held_valid = 1'b1;
         lit_len    = '0;
         run_len    = '0;
         coding     = CODE_LITERAL;
      end else if (coding == CODE_REPEAT) begin
         if (w == held_word && int'(run_len) < REPEAT_CAP) begin
            run_len++;
         end else begin
            close_repeat();
            held_word = w;
            run_len   = '0;
            lit_len   = '0;
            coding    = CODE_LITERAL;
         end
      end else begin
         if (w == held_word) begin
            close_literal();
            run_len = REP_W'(2);
            coding  = CODE_REPEAT;
         end else begin
            push_item(KIND_DATA, held_word);
            lit_len++;
            held_word = w;
         end
      end

      if (fin) begin
         if (coding == CODE_REPEAT) begin
            close_repeat();
         end else begin
            push_item(KIND_DATA, held_word);
            lit_len++;
            close_literal();
         end
         expected_q[expected_q.size() - 1].final_flag = 1'b1;
         held_word  = '0;
         held_valid = 1'b0;
         run_len    = '0;
         lit_len    = '0;
         coding     = CODE_IDLE;
         ctl_count  = '0;
         data_count = '0;
         word_pos   = 0;
      end
   endfunction

   task automatic check_field(input string name, input int unsigned expv,
                              input int unsigned actv);
      if (expv != actv) begin
         $error("%s mismatch: expected %0h, got %0h", name, expv, actv);
         err_count++;
      end
   endtask

   task automatic check_item();
      enc_item_type want;
      if (expected_q.size() == 0) begin
         $error("unexpected item: kind %0d value %0h", rsp_tuser, rsp_tdata[15:0]);
         err_count++;
      end else begin
         want = expected_q.pop_front();
         check_field("stream_kind", want.kind, rsp_tuser);
         check_field("out_value", want.value, rsp_tdata[15:0]);
         check_field("final_result", want.final_flag, rsp_tlast);
         check_field("control_total", want.ctl_total, rsp_tdata[31:16]);
         check_field("word_total", want.word_total, rsp_tdata[45:32]);
      end
      if (rsp_tuser == KIND_CONTROL) ctl_seen++;
      else data_seen++;
      if (rsp_tlast) screens_out++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            encode_word(req_tdata, req_tlast);
            words_in++;
         end
         if (rsp_tvalid && rsp_tready) check_item();
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("word_run_length_encoder_core test failed");
      $finish;
   end

   task automatic send_word(input logic [15:0] w, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_run(input logic [15:0] w, input int n, input logic last);
      for (int i = 0; i < n; i++) send_word(w, last && (i == n - 1));
   endtask

   task automatic send_literal(input logic [15:0] first, input int n, input logic last);
      for (int i = 0; i < n; i++) send_word(first + 16'(i), last && (i == n - 1));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
   endtask

   task automatic test_directed();
      send_word(16'hFFFF, 1'b1);
      send_run(16'h0000, 2, 1'b1);
      send_word(16'hA5A5, 1'b0);
      send_run(16'h5A5A, 3, 1'b0);
      send_word(16'h1234, 1'b1);
      send_word(16'h0001, 1'b0);
      send_word(16'h0002, 1'b0);
      send_word(16'h8000, 1'b0);
      send_word(16'h7FFF, 1'b1);
      send_run(16'hFFFF, 4, 1'b0);
      send_word(16'h0000, 1'b0);
      send_run(16'h0000, 2, 1'b0);
      send_word(16'hFFFF, 1'b1);
   endtask

   task automatic test_long_runs();
      send_run(16'hF0F0, 128, 1'b0);
      send_literal(16'h4000, 129, 1'b0);
      send_run(16'h5555, 2, 1'b1);
   endtask

   task automatic test_random_screens(input int n_words);
      int sent;
      int pick;
      int len;
      logic [15:0] w;
      sent = 0;
      while (sent < n_words) begin
         pick = $urandom_range(9);
         if (pick < 3) begin
            send_word(16'($urandom), $urandom_range(7) == 0);
            sent++;
         end else if (pick < 6) begin
            len = $urandom_range(8, 2);
            send_run(16'($urandom), len, $urandom_range(5) == 0);
            sent += len;
         end else begin
            len = $urandom_range(8, 1);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(5))
                  0: w = 16'h0000;
                  1: w = 16'hFFFF;
                  2: w = 16'h8000;
                  default: w = 16'($urandom);
               endcase
               send_word(w, (i == len - 1) && ($urandom_range(5) == 0));
               sent++;
            end
         end
      end
      send_word(16'($urandom), 1'b1);
   endtask

   task automatic test_drain_pause();
      send_run(16'h7777, 5, 1'b0);
      send_word(16'h1111, 1'b0);
      wait_drained();
      send_run(16'h2222, 2, 1'b1);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 17;
      rsp_idle_pct  = 79;
      test_directed();
      test_random_screens(25);
      test_drain_pause();

      send_idle_pct = 79;
      rsp_idle_pct  = 17;
      test_long_runs();
      test_random_screens(25);

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_random_screens(25);

      wait_drained();
      repeat (16) @(posedge clock);

      $display("Sent %0d screen words; checked %0d control bytes and %0d data words",
               words_in, ctl_seen, data_seen);
      $display("Closed %0d screens, including long repeat and long literal runs",
               screens_out);
      if (err_count == 0 && expected_q.size() == 0) begin
         $display("word_run_length_encoder_core test passed");
      end else begin
         $display("word_run_length_encoder_core test failed");
      end
      $finish;
   end

endmodule

// File: word_run_length_encoder_core.f
rtl/wrle_pkg.sv
rtl/wrle_front.sv
rtl/wrle_queue.sv
rtl/wrle_back.sv
rtl/word_run_length_encoder_core.sv
bench/word_run_length_encoder_core_tb.sv
